### design/tbo2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbo2d_pkg: shared types and helpers for the triangle/box overlap unit
// Sign codes of coordinate differences and the sign rules for their products.
// ----------------------------------------------------------------------------
package tbo2d_pkg;

  localparam int unsigned NumTriEdges = 3;
  localparam int unsigned NumCorners  = 4;

  // sign of a difference: negative, zero or (neither) positive
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // product of two signed quantities is strictly positive
  function automatic logic prod_pos(input sgn_t a, input sgn_t b);
    return !a.zero && !b.zero && (a.neg == b.neg);
  endfunction

  // product of two signed quantities is zero or positive
  function automatic logic prod_nonneg(input sgn_t a, input sgn_t b);
    return a.zero || b.zero || (a.neg == b.neg);
  endfunction

endpackage

### design/triangle_box_overlap_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_box_overlap_2d_unit: planar triangle versus box overlap test
// Separating-edge test in exact integer arithmetic, three register stages.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the three vertices and the box bounds and raise start_i for one
//   cycle per item. busy_o is always low, so an item is taken every cycle
//   start_i is high; items may follow back to back.
//   After an item is taken, done_o is high for one cycle and
//   overlaps_o holds its result (1 = overlap, 0 = separated). Results leave
//   in the order the items came in, one per item.
//   Throughput is one item per clock; the stages are the difference stage,
//   the multiplier stage and the sum/sign stage of the twelve
//   corner-against-triangle-edge products.
//   Box edges are checked with sign logic on compares in the first stage.
//   The triangle must be wound clockwise, like the box corners.
//   Reset clears the stage valid bits; items in flight are dropped and no
//   result is shown until a new item has passed the pipeline.
//   The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module triangle_box_overlap_2d_unit
  import tbo2d_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] vert_a_x_i,
  input  logic signed [COORD_BITS-1:0] vert_a_y_i,
  input  logic signed [COORD_BITS-1:0] vert_b_x_i,
  input  logic signed [COORD_BITS-1:0] vert_b_y_i,
  input  logic signed [COORD_BITS-1:0] vert_c_x_i,
  input  logic signed [COORD_BITS-1:0] vert_c_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  output logic                         done_o,
  output logic                         overlaps_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic signed [COORD_BITS-1:0] tx [NumTriEdges];
  logic signed [COORD_BITS-1:0] ty [NumTriEdges];
  logic signed [COORD_BITS-1:0] cx [NumCorners];
  logic signed [COORD_BITS-1:0] cy [NumCorners];

  // stage 1: differences and box edge verdict
  logic signed [DW-1:0] dx_d [NumTriEdges][NumCorners];
  logic signed [DW-1:0] dy_d [NumTriEdges][NumCorners];
  logic signed [DW-1:0] ex_d [NumTriEdges];
  logic signed [DW-1:0] ey_d [NumTriEdges];
  logic signed [DW-1:0] dx_q [NumTriEdges][NumCorners];
  logic signed [DW-1:0] dy_q [NumTriEdges][NumCorners];
  logic signed [DW-1:0] ex_q [NumTriEdges];
  logic signed [DW-1:0] ey_q [NumTriEdges];
  logic                 box_ok_d, box_ok1_q;
  logic                 vld1_q;

  // stage 2: products
  logic signed [PW-1:0] pa_d [NumTriEdges][NumCorners];
  logic signed [PW-1:0] pb_d [NumTriEdges][NumCorners];
  logic signed [PW-1:0] pa_q [NumTriEdges][NumCorners];
  logic signed [PW-1:0] pb_q [NumTriEdges][NumCorners];
  logic                 box_ok2_q;
  logic                 vld2_q;

  // stage 3: sums, signs and result
  logic signed [SW-1:0] sum [NumTriEdges][NumCorners];
  logic [NumTriEdges-1:0] edge_ok;
  logic                 overlaps_d, overlaps_q;
  logic                 vld3_q;

  assign busy_o = 1'b0;

  assign tx[0] = vert_a_x_i;
  assign ty[0] = vert_a_y_i;
  assign tx[1] = vert_b_x_i;
  assign ty[1] = vert_b_y_i;
  assign tx[2] = vert_c_x_i;
  assign ty[2] = vert_c_y_i;

  assign cx[0] = box_min_x_i;
  assign cy[0] = box_min_y_i;
  assign cx[1] = box_min_x_i;
  assign cy[1] = box_max_y_i;
  assign cx[2] = box_max_x_i;
  assign cy[2] = box_max_y_i;
  assign cx[3] = box_max_x_i;
  assign cy[3] = box_min_y_i;

  // box edges: each D is one difference times a box extent
  always_comb begin
    sgn_t h_ext, v_ext, h_neg_ext, v_neg_ext;
    sgn_t sx_min, sx_max, sy_min, sy_max;
    logic left_ok, top_ok, right_ok, bottom_ok;
    h_ext     = '{neg: box_max_x_i < box_min_x_i, zero: box_max_x_i == box_min_x_i};
    v_ext     = '{neg: box_max_y_i < box_min_y_i, zero: box_max_y_i == box_min_y_i};
    h_neg_ext = '{neg: box_min_x_i < box_max_x_i, zero: box_max_x_i == box_min_x_i};
    v_neg_ext = '{neg: box_min_y_i < box_max_y_i, zero: box_max_y_i == box_min_y_i};
    left_ok   = 1'b0;
    top_ok    = 1'b0;
    right_ok  = 1'b0;
    bottom_ok = 1'b0;
    for (int i = 0; i < NumTriEdges; i++) begin
      sx_min = '{neg: tx[i] < box_min_x_i, zero: tx[i] == box_min_x_i};
      sx_max = '{neg: tx[i] < box_max_x_i, zero: tx[i] == box_max_x_i};
      sy_min = '{neg: ty[i] < box_min_y_i, zero: ty[i] == box_min_y_i};
      sy_max = '{neg: ty[i] < box_max_y_i, zero: ty[i] == box_max_y_i};
      left_ok   = left_ok   | prod_nonneg(sx_min, v_ext);
      top_ok    = top_ok    | prod_pos(sy_max, h_neg_ext);
      right_ok  = right_ok  | prod_pos(sx_max, v_neg_ext);
      bottom_ok = bottom_ok | prod_nonneg(sy_min, h_ext);
    end
    box_ok_d = left_ok & top_ok & right_ok & bottom_ok;
  end

  // triangle edge directions and corner offsets
  always_comb begin
    for (int i = 0; i < NumTriEdges; i++) begin
      ey_d[i] = DW'(ty[(i + 1) % NumTriEdges]) - DW'(ty[i]);
      ex_d[i] = DW'(tx[i]) - DW'(tx[(i + 1) % NumTriEdges]);
      for (int k = 0; k < NumCorners; k++) begin
        dx_d[i][k] = DW'(cx[k]) - DW'(tx[i]);
        dy_d[i][k] = DW'(cy[k]) - DW'(ty[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumTriEdges; i++) begin
      for (int k = 0; k < NumCorners; k++) begin
        pa_d[i][k] = PW'(dx_q[i][k]) * PW'(ey_q[i]);
        pb_d[i][k] = PW'(dy_q[i][k]) * PW'(ex_q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumTriEdges; i++) begin
      edge_ok[i] = 1'b0;
      for (int k = 0; k < NumCorners; k++) begin
        sum[i][k]  = SW'(pa_q[i][k]) + SW'(pb_q[i][k]);
        edge_ok[i] = edge_ok[i] | ~sum[i][k][SW-1];
      end
    end
    overlaps_d = box_ok2_q & (&edge_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= start_i & ~busy_o;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    ex_q       <= ex_d;
    ey_q       <= ey_d;
    box_ok1_q  <= box_ok_d;
    pa_q       <= pa_d;
    pb_q       <= pb_d;
    box_ok2_q  <= box_ok1_q;
    overlaps_q <= overlaps_d;
  end

  assign done_o     = vld3_q;
  assign overlaps_o = overlaps_q;

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("item accepted but no result three cycles later");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##3 !done_o)
    else $error("result shown without an accepted item");

  a_flat_x_separated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && box_min_x_i == box_max_x_i) |-> ##3 !overlaps_o)
    else $error("box flat in x reported as overlapping");

  a_flat_y_separated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && box_min_y_i == box_max_y_i) |-> ##3 !overlaps_o)
    else $error("box flat in y reported as overlapping");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for triangle_box_overlap_2d_unit
// Sends planar triangle/box pairs through the start/busy handshake, predicts
// each overlap flag with exact 64-bit edge arithmetic and compares it with
// every done_o strobe in order. A directed set covers touching edges, flat,
// inverted and extreme boxes, degenerate and counterclockwise triangles;
// a random set follows, mostly clockwise triangles placed around the box.
// ----------------------------------------------------------------------------
module tb;

  localparam int CoordBits  = 16;
  localparam int NumRandom  = 1880;
  localparam int QuietLimit = 200;
  localparam int MaxShown   = 10;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy;
    coord_t min_x, min_y, max_x, max_y;
  } tri_box_t;

  typedef struct {
    int unsigned idx;
    bit          ovl;
  } overlap_exp_t;

  class overlap_scoreboard;
    overlap_exp_t overlap_q[$];
    int unsigned  mismatches;
    int unsigned  items_seen;

    function longint edge_d(longint qx, longint qy, longint p0x, longint p0y,
                            longint p1x, longint p1y);
      return (qx - p0x) * (p1y - p0y) + (qy - p0y) * (p0x - p1x);
    endfunction

    function bit predict_overlap(tri_box_t p);
      longint tx[3], ty[3], kx[4], ky[4];
      longint d;
      bit     hit, any, strict;
      int     nxt;
      tx[0] = p.ax; ty[0] = p.ay;
      tx[1] = p.bx; ty[1] = p.by;
      tx[2] = p.cx; ty[2] = p.cy;
      kx[0] = p.min_x; ky[0] = p.min_y;
      kx[1] = p.min_x; ky[1] = p.max_y;
      kx[2] = p.max_x; ky[2] = p.max_y;
      kx[3] = p.max_x; ky[3] = p.min_y;
      hit = 1'b1;
      // box edges: top and right need the vertex strictly inside
      for (int e = 0; e < 4; e++) begin
        nxt = (e + 1) % 4;
        strict = (e == 1) || (e == 2);
        any = 1'b0;
        for (int i = 0; i < 3; i++) begin
          d = edge_d(tx[i], ty[i], kx[e], ky[e], kx[nxt], ky[nxt]);
          if (strict ? (d > 0) : (d >= 0)) any = 1'b1;
        end
        if (!any) hit = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
        nxt = (i + 1) % 3;
        any = 1'b0;
        for (int k = 0; k < 4; k++) begin
          d = edge_d(kx[k], ky[k], tx[i], ty[i], tx[nxt], ty[nxt]);
          if (d >= 0) any = 1'b1;
        end
        if (!any) hit = 1'b0;
      end
      return hit;
    endfunction

    function void note_item(tri_box_t p);
      overlap_exp_t x;
      x.idx = items_seen;
      x.ovl = predict_overlap(p);
      overlap_q.push_back(x);
      items_seen++;
    endfunction

    function void check_result(logic got);
      overlap_exp_t x;
      if (overlap_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result: overlaps=%b with no item pending", got);
        return;
      end
      x = overlap_q.pop_front();
      if (got !== x.ovl) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("item %0d: overlaps expected %b, actual %b", x.idx, x.ovl, got);
      end
    endfunction

    function int unsigned pending();
      return overlap_q.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  logic     done_o;
  logic     overlaps_o;
  tri_box_t pair_q;
  bit       gap_mode;
  int       quiet_cycles = 0;

  overlap_scoreboard sb;

  triangle_box_overlap_2d_unit #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .vert_a_x_i (pair_q.ax),
    .vert_a_y_i (pair_q.ay),
    .vert_b_x_i (pair_q.bx),
    .vert_b_y_i (pair_q.by),
    .vert_c_x_i (pair_q.cx),
    .vert_c_y_i (pair_q.cy),
    .box_min_x_i(pair_q.min_x),
    .box_min_y_i(pair_q.min_y),
    .box_max_x_i(pair_q.max_x),
    .box_max_y_i(pair_q.max_y),
    .done_o     (done_o),
    .overlaps_o (overlaps_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic coord_t clip(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic tri_box_t make_pair(int ax, int ay, int bx, int by, int cx, int cy,
                                         int mnx, int mny, int mxx, int mxy);
    tri_box_t p;
    p.ax = clip(ax); p.ay = clip(ay);
    p.bx = clip(bx); p.by = clip(by);
    p.cx = clip(cx); p.cy = clip(cy);
    p.min_x = clip(mnx); p.min_y = clip(mny);
    p.max_x = clip(mxx); p.max_y = clip(mxy);
    return p;
  endfunction

  function automatic tri_box_t noise_pair();
    tri_box_t p;
    p.ax = coord_t'($urandom); p.ay = coord_t'($urandom);
    p.bx = coord_t'($urandom); p.by = coord_t'($urandom);
    p.cx = coord_t'($urandom); p.cy = coord_t'($urandom);
    p.min_x = coord_t'($urandom); p.min_y = coord_t'($urandom);
    p.max_x = coord_t'($urandom); p.max_y = coord_t'($urandom);
    return p;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(-32768);
      1: return coord_t'(-32767);
      2: return coord_t'(-1);
      3: return coord_t'(0);
      4: return coord_t'(1);
      5: return coord_t'(32766);
      6: return coord_t'(32767);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // vertex coordinate around a box axis, sometimes right on a bound
  function automatic coord_t near_axis(int lo, int hi, int span);
    case ($urandom_range(0, 11))
      0: return clip(lo);
      1: return clip(hi);
      default: return clip(rand_between(lo - span, hi + span));
    endcase
  endfunction

  function automatic tri_box_t shaped_pair();
    tri_box_t p;
    coord_t   t;
    longint   orient;
    int       span, w, h, x0, y0, kind;
    kind = $urandom_range(0, 99);
    if (kind >= 60 && kind < 75) return noise_pair();
    if (kind >= 85) begin
      p = noise_pair();
      p.ax = extreme_coord(); p.ay = extreme_coord();
      p.bx = extreme_coord(); p.by = extreme_coord();
      p.cx = extreme_coord(); p.cy = extreme_coord();
      p.min_x = extreme_coord(); p.min_y = extreme_coord();
      p.max_x = extreme_coord(); p.max_y = extreme_coord();
      return p;
    end
    case ($urandom_range(0, 3))
      0: span = 16;
      1: span = 256;
      2: span = 4096;
      default: span = 32767;
    endcase
    x0 = rand_between(-32768, 32767);
    y0 = rand_between(-32768, 32767);
    w = rand_between(0, span);
    h = rand_between(0, span);
    p.min_x = clip(x0 - w / 2);
    p.min_y = clip(y0 - h / 2);
    p.max_x = clip(int'(p.min_x) + w);
    p.max_y = clip(int'(p.min_y) + h);
    p.ax = near_axis(p.min_x, p.max_x, span);
    p.ay = near_axis(p.min_y, p.max_y, span);
    p.bx = near_axis(p.min_x, p.max_x, span);
    p.by = near_axis(p.min_y, p.max_y, span);
    p.cx = near_axis(p.min_x, p.max_x, span);
    p.cy = near_axis(p.min_y, p.max_y, span);
    // wind clockwise
    orient = (longint'(p.cx) - p.ax) * (longint'(p.by) - p.ay)
           + (longint'(p.cy) - p.ay) * (longint'(p.ax) - p.bx);
    if (orient < 0) begin
      t = p.bx; p.bx = p.cx; p.cx = t;
      t = p.by; p.by = p.cy; p.cy = t;
    end
    if (kind >= 75) begin
      case ($urandom_range(0, 5))
        0: p.max_x = p.min_x;
        1: p.max_y = p.min_y;
        2: begin t = p.min_x; p.min_x = p.max_x; p.max_x = t; end
        3: begin t = p.min_y; p.min_y = p.max_y; p.max_y = t; end
        4: begin p.bx = p.ax; p.by = p.ay; end
        default: begin p.bx = p.ax; p.by = p.ay; p.cx = p.ax; p.cy = p.ay; end
      endcase
    end
    return p;
  endfunction

  task automatic idle_cycles(int n);
    start_i <= 1'b0;
    pair_q  <= noise_pair();
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_pair(tri_box_t p, bit allow_gap);
    if (allow_gap && gap_mode && $urandom_range(0, 2) == 0)
      idle_cycles($urandom_range(1, 7));
    pair_q  <= p;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start_i && !busy_o) begin
        sb.note_item(pair_q);
      end
      if (done_o) begin
        sb.check_result(overlaps_o);
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("triangle_box_overlap_2d_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    tri_box_t directed_q[$];
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    gap_mode = 1'b1;
    pair_q = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // triangle inside box, box inside triangle, apart
    directed_q.push_back(make_pair(0, 0, 0, 2560, 2560, 0, -256, -256, 5120, 5120));
    directed_q.push_back(make_pair(-10000, -10000, -10000, 20000, 20000, -10000,
                                   0, 0, 256, 256));
    directed_q.push_back(make_pair(0, 0, 0, 100, 100, 0, 1000, 1000, 2000, 2000));
    // vertex on left, right, bottom, top box lines
    directed_q.push_back(make_pair(0, 0, 0, 100, 100, 50, 100, 0, 200, 100));
    directed_q.push_back(make_pair(0, 50, 100, 100, 100, 0, -200, 0, 0, 100));
    directed_q.push_back(make_pair(0, 0, 50, 100, 100, 0, 0, 100, 100, 200));
    directed_q.push_back(make_pair(0, 100, 50, 200, 100, 100, 0, 0, 100, 100));
    // flat and point boxes
    directed_q.push_back(make_pair(0, 0, 0, 2560, 2560, 0, 256, -256, 256, 5120));
    directed_q.push_back(make_pair(0, 0, 0, 2560, 2560, 0, -256, 256, 5120, 256));
    directed_q.push_back(make_pair(0, 0, 0, 2560, 2560, 0, 256, 256, 256, 256));
    // inverted boxes
    directed_q.push_back(make_pair(0, 0, 0, 2560, 2560, 0, 5120, -256, -256, 5120));
    directed_q.push_back(make_pair(0, 0, 0, 2560, 2560, 0, 5120, 5120, -256, -256));
    // zero-length edges
    directed_q.push_back(make_pair(0, 0, 0, 0, 2560, 0, -256, -256, 5120, 5120));
    directed_q.push_back(make_pair(300, 300, 300, 300, 300, 300, 0, 0, 1000, 1000));
    // counterclockwise triangle
    directed_q.push_back(make_pair(0, 0, 2560, 0, 0, 2560, -256, -256, 5120, 5120));
    // extremes
    directed_q.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
    directed_q.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
    directed_q.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, -32768,
                                   -32768, -32768, 32767, 32767));
    directed_q.push_back(make_pair(-32768, -32768, 32767, -32768, -32768, 32767,
                                   -32768, -32768, 32767, 32767));
    directed_q.push_back(make_pair(-1, -1, -1, 1, 1, -1, -32768, -32768, 32767, 32767));
    directed_q.push_back(make_pair(32767, 32767, 32767, -32768, -32768, 32767,
                                   32767, -32768, -32768, 32767));
    directed_q.push_back(make_pair(-32768, 32767, 32767, 32767, 32767, -32768,
                                   -32768, -32768, -32767, -32767));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_pair(directed_q[i], 1'b1);
    drain_results();

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 40 == 0) gap_mode = ($urandom_range(0, 2) != 0);
      if (n == NumRandom / 2) drain_results();
      send_pair(shaped_pair(), n < NumRandom - 200);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("triangle_box_overlap_2d_unit: match");
    end else begin
      $display("triangle_box_overlap_2d_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/tbo2d_pkg.sv
design/triangle_box_overlap_2d_unit.sv
test/tb.sv
